// ===== rtl/bdq_pkg.sv =====
// bdq_pkg: shared types and constants of the bounded double-ended queue
// used by bdq_ctrl, bdq_dpath and bounded_double_ended_queue; no dependencies
`default_nettype none

package bdq_pkg;

   // depth of the circular entry store
   localparam int STORE_DEPTH = 1024;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // fixed field widths
   localparam int CMD_W  = 3;
   localparam int STAT_W = 3;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 11;
   localparam int CAP_W  = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_LEFT  = 3'd0,
      CMD_PUSH_RIGHT = 3'd1,
      CMD_POP_LEFT   = 3'd2,
      CMD_POP_RIGHT  = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_PUSHED  = 3'd0,
      ST_FULL    = 3'd1,
      ST_POPPED  = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the incoming beat
      logic exec;   // carry out the captured command
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/bounded_double_ended_queue.sv =====
// bounded_double_ended_queue: top level of the bounded double-ended queue
// depends on bdq_pkg, bdq_ctrl and bdq_dpath
`default_nettype none

// A deque of 32-bit signed values held in a 1024-entry circular store. A command
// beat is taken when start is high and busy is low; busy then stays high while
// the command runs against the store in the execute state, and the result beat is
// shown on the rsp_ ports in the respond state that follows, with rsp_strobe high
// for exactly one cycle. The receiver cannot stall: the result must be captured in
// that cycle. A new command may be taken in the same cycle that a result is shown,
// but not while busy is high. Pushes beyond the usable capacity (csr_capacity,
// saturated at the store depth) report full; pops on an empty queue report empty
// with a zero value. csr_capacity may be written at any time the queue is idle;
// csr_ready is always high. The store needs no clearing pass after reset.

module bounded_double_ended_queue import bdq_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // command beat
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic        [CMD_W-1:0]  req_command,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   // result beat
   output logic                          rsp_strobe,
   output logic             [STAT_W-1:0] rsp_status,
   output logic signed      [DATA_W-1:0] rsp_pop_value,
   output logic             [OCC_W-1:0]  rsp_occupancy,
   // capacity register write
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic        [CAP_W-1:0]  csr_capacity
);

   ctrl_cmd_type ctrl_cmd;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencing: idle, execute, respond
   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .ctrl_cmd   (ctrl_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // store, pointers, count and capacity
   bdq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctrl_cmd       (ctrl_cmd),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .cap_wr         (csr_valid && csr_ready),
      .cap_wdata      (csr_capacity),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_occupancy  (rsp_occupancy)
   );

   // a taken beat always blocks the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted command");

   // results are never shown in two adjacent cycles
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobes in adjacent cycles");

   // each result follows an execute cycle
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a preceding execute cycle");

   // only a successful pop carries a value
   a_pop_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_POPPED)) |-> (rsp_pop_value == '0))
      else $error("non-zero value on a result that is not a pop");

   // the count never exceeds the store depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(rsp_occupancy) <= (CNT_W + 1)'(STORE_DEPTH))
      else $error("occupancy beyond the store depth");

endmodule

`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
// bdq_ctrl: sequencing state machine of the bounded double-ended queue
// depends on bdq_pkg
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output ctrl_cmd_type ctrl_cmd,
   output logic        busy,
   output logic        rsp_strobe
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;
   logic      load;

   assign load = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  state_in = load ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = load ? S_EXEC : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in == S_EXEC);
         strobe_ff <= (state_ff == S_EXEC);
      end
   end

   assign ctrl_cmd.load = load;
   assign ctrl_cmd.exec = (state_ff == S_EXEC);
   assign busy          = busy_ff;
   assign rsp_strobe    = strobe_ff;

endmodule

`default_nettype wire

// ===== rtl/bdq_dpath.sv =====
// bdq_dpath: entry store, end pointers, count and capacity register
// depends on bdq_pkg; driven by bdq_ctrl
`default_nettype none

module bdq_dpath import bdq_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             ctrl_cmd,
   input  wire logic        [CMD_W-1:0]  req_command,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   input  wire logic                     cap_wr,
   input  wire logic        [CAP_W-1:0]  cap_wdata,
   output logic             [STAT_W-1:0] rsp_status,
   output logic signed      [DATA_W-1:0] rsp_pop_value,
   output logic             [OCC_W-1:0]  rsp_occupancy
);

   logic [DATA_W-1:0] store [STORE_DEPTH];

   logic [CMD_W-1:0]  cmd_ff;
   logic [DATA_W-1:0] val_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [PTR_W-1:0]  left_ff, left_in;
   logic [PTR_W-1:0]  right_ff, right_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        status_ff, status_in;
   logic              popped_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic [PTR_W-1:0]  left_inc, left_dec, right_inc, right_dec;
   logic [CNT_W-1:0]  usable_cap;
   logic              is_full, is_empty;
   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  wr_addr, rd_addr;

   // circular pointer steps, valid for any depth
   assign left_inc  = (left_ff == PTR_W'(STORE_DEPTH - 1)) ? '0 : left_ff + 1'b1;
   assign left_dec  = (left_ff == '0) ? PTR_W'(STORE_DEPTH - 1) : left_ff - 1'b1;
   assign right_inc = (right_ff == PTR_W'(STORE_DEPTH - 1)) ? '0 : right_ff + 1'b1;
   assign right_dec = (right_ff == '0) ? PTR_W'(STORE_DEPTH - 1) : right_ff - 1'b1;

   // capacity saturates at the store depth
   always_comb begin
      if ((CAP_W + 1)'(cap_ff) > (CAP_W + 1)'(STORE_DEPTH)) begin
         usable_cap = CNT_W'(STORE_DEPTH);
      end else begin
         usable_cap = CNT_W'(cap_ff);
      end
   end

   assign is_full  = (count_ff >= usable_cap);
   assign is_empty = (count_ff == '0);

   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      count_in  = count_ff;
      status_in = ST_EMPTY;
      wr_en     = 1'b0;
      wr_addr   = right_ff;
      rd_en     = 1'b0;
      rd_addr   = left_ff;
      case (cmd_ff)
         CMD_PUSH_LEFT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               left_in   = left_dec;
               wr_en     = 1'b1;
               wr_addr   = left_dec;
               count_in  = count_ff + 1'b1;
               status_in = ST_PUSHED;
            end
         end
         CMD_PUSH_RIGHT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               right_in  = right_inc;
               wr_en     = 1'b1;
               wr_addr   = right_ff;
               count_in  = count_ff + 1'b1;
               status_in = ST_PUSHED;
            end
         end
         CMD_POP_LEFT: begin
            if (!is_empty) begin
               rd_en     = 1'b1;
               rd_addr   = left_ff;
               left_in   = left_inc;
               count_in  = count_ff - 1'b1;
               status_in = ST_POPPED;
            end
         end
         CMD_POP_RIGHT: begin
            if (!is_empty) begin
               rd_en     = 1'b1;
               rd_addr   = right_dec;
               right_in  = right_dec;
               count_in  = count_ff - 1'b1;
               status_in = ST_POPPED;
            end
         end
         CMD_CLEAR: begin
            left_in   = '0;
            right_in  = '0;
            count_in  = '0;
            status_in = ST_CLEARED;
         end
         default: begin
            status_in = ST_EMPTY;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         count_ff  <= '0;
         cap_ff    <= CAP_RESET;
         popped_ff <= 1'b0;
      end else begin
         if (cap_wr) begin
            cap_ff <= cap_wdata;
         end
         if (ctrl_cmd.exec) begin
            left_ff   <= left_in;
            right_ff  <= right_in;
            count_ff  <= count_in;
            popped_ff <= rd_en;
         end
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff <= req_command;
         val_ff <= req_push_value;
      end
      if (ctrl_cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // entry store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (ctrl_cmd.exec && wr_en) begin
         store[wr_addr] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.exec && rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_pop_value = popped_ff ? $signed(rd_data_ff) : '0;
   assign rsp_occupancy = OCC_W'(count_ff);

endmodule

`default_nettype wire
